// ===== rtl/core/pwe_pkg.sv =====
// Shared constants, codes and types for the MCP/SCAD penalty weight engine.
// No dependencies; every other file in rtl/core imports this package.
package pwe_pkg;

  localparam int DATA_W     = 32;             // coefficient, gradient, multiplier operands
  localparam int APB_DATA_W = 32;
  localparam int VAL_W      = 31;             // lambda, weight, value
  localparam int RG_W       = 25;             // 1/gamma
  localparam int FRAC_W     = 24;             // fraction bits of Q8.24
  localparam int SUM_W      = 48;             // accumulator width
  localparam int TOTAL_W    = 47;             // reported totals
  localparam int STAT_W     = 33;             // stationarity residual, Q9.24
  localparam int PROD_W     = 2 * DATA_W;
  localparam int HI_W       = PROD_W - FRAC_W;      // product >> FRAC_W
  localparam int H25_W      = PROD_W - FRAC_W - 1;  // product >> (FRAC_W+1)
  localparam int L2_W       = 2 * VAL_W - FRAC_W;   // lambda^2 >> FRAC_W
  localparam int SQ_W       = 2 * VAL_W - FRAC_W;   // slope drop / first product
  localparam int WA_W       = 2 * VAL_W - FRAC_W;   // weight * |beta| >> FRAC_W
  localparam int FSUM_W     = PROD_W + DATA_W;      // split flat-level product
  localparam int REG_IDX_W  = 3;
  localparam int PADDR_W    = REG_IDX_W + 2;

  localparam int Q_DEPTH    = 2;
  localparam int Q_PTR_W    = $clog2(Q_DEPTH);
  localparam int Q_CNT_W    = $clog2(Q_DEPTH + 1);

  localparam logic [VAL_W-1:0]  VAL_MAX = {VAL_W{1'b1}};
  localparam logic [SUM_W-1:0]  SUM_MAX = {1'b0, {(SUM_W-1){1'b1}}};
  localparam logic [DATA_W-1:0] ONE     = DATA_W'(1) << FRAC_W;

  localparam logic [VAL_W-1:0]  GAMMA_RST = 31'd50331648;
  localparam logic [RG_W-1:0]   RG_RST    = 25'd5592405;
  localparam logic [VAL_W-1:0]  RGL_RST   = 31'd8388608;

  typedef enum logic {MODE_MCP = 1'b0, MODE_SCAD = 1'b1} mode_t;

  typedef enum logic [1:0] {ZONE_ZERO, ZONE_POS, ZONE_NEG} zone_t;

  typedef enum logic [REG_IDX_W-1:0] {
    REG_MODE, REG_LAMBDA, REG_GAMMA, REG_RG, REG_RGL, REG_TOL
  } reg_idx_t;

  // Classified coefficient as it travels from the front end to the back end
  typedef struct packed {
    logic [DATA_W-1:0]        mag;
    logic [DATA_W-1:0]        excess;
    logic                     a_le_lam;
    logic                     a_zero;
    zone_t                    zone;
    logic signed [DATA_W-1:0] gradient;
    logic                     last;
  } item_t;

  // Register file contents plus the constants derived from them
  typedef struct packed {
    mode_t             mode;
    logic [VAL_W-1:0]  lambda;
    logic [RG_W-1:0]   rg;
    logic [VAL_W-1:0]  rgl;
    logic [VAL_W-1:0]  tol;
    logic [L2_W-1:0]   l2;
    logic [VAL_W-1:0]  flat_mcp;
    logic              flat_mcp_sat;
    logic [VAL_W-1:0]  flat_scad;
    logic              flat_scad_sat;
  } cfg_t;

endpackage

// ===== rtl/core/pwe_in_if.sv =====
// Input word channel: one coefficient with its gradient and end-of-set mark.
// Depends on pwe_pkg.
interface pwe_in_if;
  import pwe_pkg::*;

  logic                     valid;
  logic                     ready;
  logic signed [DATA_W-1:0] coefficient;
  logic signed [DATA_W-1:0] gradient;
  logic                     last_item;

  modport source (output valid, coefficient, gradient, last_item, input ready);
  modport sink (input valid, coefficient, gradient, last_item, output ready);
endinterface

// ===== rtl/core/pwe_out_if.sv =====
// Result word channel: weight, value, running totals and flags for one coefficient.
// Depends on pwe_pkg.
interface pwe_out_if;
  import pwe_pkg::*;

  logic               valid;
  logic               ready;
  logic [VAL_W-1:0]   weight;
  logic [VAL_W-1:0]   penalty_value;
  logic [TOTAL_W-1:0] penalty_total;
  logic [TOTAL_W-1:0] weighted_l1_total;
  logic [TOTAL_W-1:0] tangent_total;
  logic [STAT_W-1:0]  stationarity_max;
  logic               overflow;
  logic               last_result;

  modport source (output valid, weight, penalty_value, penalty_total, weighted_l1_total,
                  tangent_total, stationarity_max, overflow, last_result, input ready);
  modport sink (input valid, weight, penalty_value, penalty_total, weighted_l1_total,
                tangent_total, stationarity_max, overflow, last_result, output ready);
endinterface

// ===== rtl/core/pwe_cfg.sv =====
// APB register file and the sequencer that derives lambda^2 and the flat penalty levels.
// Depends on pwe_pkg.
module pwe_cfg (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [pwe_pkg::PADDR_W-1:0]      paddr,
  input  logic [pwe_pkg::APB_DATA_W-1:0]   pwdata,
  output logic [pwe_pkg::APB_DATA_W-1:0]   prdata,
  output logic                             pready,
  output pwe_pkg::cfg_t                    cfg,
  output logic                             busy
);
  import pwe_pkg::*;

  typedef enum logic [2:0] {
    CS_IDLE, CS_SQ, CS_L2, CS_MLO, CS_MHI, CS_MFIN, CS_SHI, CS_SFIN
  } cstate_t;

  cstate_t            state;
  mode_t              mode;
  logic [VAL_W-1:0]   lambda;
  logic [VAL_W-1:0]   gamma;
  logic [RG_W-1:0]    rg;
  logic [VAL_W-1:0]   rgl;
  logic [VAL_W-1:0]   tol;
  logic [L2_W-1:0]    l2;
  logic [DATA_W-1:0]  gamma_p1;
  logic [PROD_W-1:0]  preg;
  logic [PROD_W-1:0]  plo;
  logic [VAL_W-1:0]   flat_mcp;
  logic               flat_mcp_sat;
  logic [VAL_W-1:0]   flat_scad;
  logic               flat_scad_sat;

  logic               wr_en;
  reg_idx_t           wr_idx;
  logic [DATA_W-1:0]  mul_a;
  logic [DATA_W-1:0]  mul_b;
  logic [PROD_W-1:0]  mul_p;
  logic [FSUM_W-1:0]  fsum;
  logic [FSUM_W-1:0]  fshift;
  logic               fsat;
  logic [VAL_W-1:0]   flat_val;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;
  assign wr_idx = reg_idx_t'(paddr[PADDR_W-1:2]);
  assign busy   = (state != CS_IDLE);

  always_comb begin
    case (wr_idx)
      REG_MODE:   prdata = APB_DATA_W'(mode);
      REG_LAMBDA: prdata = APB_DATA_W'(lambda);
      REG_GAMMA:  prdata = APB_DATA_W'(gamma);
      REG_RG:     prdata = APB_DATA_W'(rg);
      REG_RGL:    prdata = APB_DATA_W'(rgl);
      REG_TOL:    prdata = APB_DATA_W'(tol);
      default:    prdata = '0;
    endcase
  end

  // gamma * l2 and (gamma+1) * l2 are split on l2 into a low 32-bit and a high part
  always_comb begin
    case (state)
      CS_SQ: begin
        mul_a = DATA_W'(lambda);
        mul_b = DATA_W'(lambda);
      end
      CS_MLO: begin
        mul_a = DATA_W'(gamma);
        mul_b = l2[DATA_W-1:0];
      end
      CS_MHI: begin
        mul_a = DATA_W'(gamma);
        mul_b = DATA_W'(l2 >> DATA_W);
      end
      CS_MFIN: begin
        mul_a = gamma_p1;
        mul_b = l2[DATA_W-1:0];
      end
      CS_SHI: begin
        mul_a = gamma_p1;
        mul_b = DATA_W'(l2 >> DATA_W);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign mul_p    = mul_a * mul_b;
  assign fsum     = (FSUM_W'(preg) << DATA_W) + FSUM_W'(plo);
  assign fshift   = fsum >> (FRAC_W + 1);
  assign fsat     = fshift > FSUM_W'(VAL_MAX);
  assign flat_val = fsat ? VAL_MAX : fshift[VAL_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= CS_IDLE;
      mode          <= MODE_MCP;
      lambda        <= '0;
      gamma         <= GAMMA_RST;
      rg            <= RG_RST;
      rgl           <= RGL_RST;
      tol           <= '0;
      l2            <= '0;
      gamma_p1      <= '0;
      preg          <= '0;
      plo           <= '0;
      flat_mcp      <= '0;
      flat_mcp_sat  <= 1'b0;
      flat_scad     <= '0;
      flat_scad_sat <= 1'b0;
    end else if (wr_en) begin
      case (wr_idx)
        REG_MODE:   mode   <= mode_t'(pwdata[0]);
        REG_LAMBDA: lambda <= pwdata[VAL_W-1:0];
        REG_GAMMA:  gamma  <= pwdata[VAL_W-1:0];
        REG_RG:     rg     <= pwdata[RG_W-1:0];
        REG_RGL:    rgl    <= pwdata[VAL_W-1:0];
        REG_TOL:    tol    <= pwdata[VAL_W-1:0];
        default: ;
      endcase
      // recompute the derived constants from scratch
      state <= CS_SQ;
    end else begin
      case (state)
        CS_SQ: begin
          preg  <= mul_p;
          state <= CS_L2;
        end
        CS_L2: begin
          l2       <= L2_W'(preg >> FRAC_W);
          gamma_p1 <= DATA_W'(gamma) + ONE;
          state    <= CS_MLO;
        end
        CS_MLO: begin
          preg  <= mul_p;
          state <= CS_MHI;
        end
        CS_MHI: begin
          plo   <= preg;
          preg  <= mul_p;
          state <= CS_MFIN;
        end
        CS_MFIN: begin
          flat_mcp     <= flat_val;
          flat_mcp_sat <= fsat;
          preg         <= mul_p;
          state        <= CS_SHI;
        end
        CS_SHI: begin
          plo   <= preg;
          preg  <= mul_p;
          state <= CS_SFIN;
        end
        CS_SFIN: begin
          flat_scad     <= flat_val;
          flat_scad_sat <= fsat;
          state         <= CS_IDLE;
        end
        default: state <= CS_IDLE;
      endcase
    end
  end

  assign cfg.mode          = mode;
  assign cfg.lambda        = lambda;
  assign cfg.rg            = rg;
  assign cfg.rgl           = rgl;
  assign cfg.tol           = tol;
  assign cfg.l2            = l2;
  assign cfg.flat_mcp      = flat_mcp;
  assign cfg.flat_mcp_sat  = flat_mcp_sat;
  assign cfg.flat_scad     = flat_scad;
  assign cfg.flat_scad_sat = flat_scad_sat;

endmodule

// ===== rtl/core/pwe_front.sv =====
// Front end: takes input words, forms |beta| and its excess over lambda, and
// classifies the coefficient against the zero tolerance. Depends on pwe_pkg.
module pwe_front (
  pwe_in_if.sink          item,
  input  pwe_pkg::cfg_t   cfg,
  input  logic            cfg_busy,
  output logic            push_valid,
  input  logic            push_ready,
  output pwe_pkg::item_t  push_data
);
  import pwe_pkg::*;

  logic signed [DATA_W:0] coef_x;
  logic signed [DATA_W:0] tol_x;
  logic [DATA_W:0]        mag_x;
  logic [DATA_W-1:0]      lam_x;

  // hold off input while the derived constants are being rebuilt
  assign item.ready = push_ready && !cfg_busy;
  assign push_valid = item.valid && !cfg_busy;

  assign coef_x = {item.coefficient[DATA_W-1], item.coefficient};
  assign tol_x  = $signed({2'b00, cfg.tol});
  assign mag_x  = coef_x[DATA_W] ? (DATA_W+1)'(-coef_x) : coef_x;
  assign lam_x  = DATA_W'(cfg.lambda);

  always_comb begin
    push_data.mag      = mag_x[DATA_W-1:0];
    push_data.excess   = mag_x[DATA_W-1:0] - lam_x;
    push_data.a_le_lam = mag_x[DATA_W-1:0] <= lam_x;
    push_data.a_zero   = mag_x[DATA_W-1:0] == '0;
    push_data.gradient = item.gradient;
    push_data.last     = item.last_item;
    if (coef_x > tol_x) begin
      push_data.zone = ZONE_POS;
    end else if (coef_x < -tol_x) begin
      push_data.zone = ZONE_NEG;
    end else begin
      push_data.zone = ZONE_ZERO;
    end
  end

endmodule

// ===== rtl/core/pwe_queue.sv =====
// Two-entry queue of classified words between the front and back ends.
// Depends on pwe_pkg.
module pwe_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic            push_valid,
  output logic            push_ready,
  input  pwe_pkg::item_t  push_data,
  output logic            pop_valid,
  input  logic            pop_ready,
  output pwe_pkg::item_t  pop_data
);
  import pwe_pkg::*;

  item_t               entry [Q_DEPTH];
  logic [Q_PTR_W-1:0]  wr_ptr;
  logic [Q_PTR_W-1:0]  rd_ptr;
  logic [Q_CNT_W-1:0]  count;
  logic                push;
  logic                pop;

  assign push_ready = count != Q_CNT_W'(Q_DEPTH);
  assign pop_valid  = count != '0;
  assign pop_data   = entry[rd_ptr];
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (push) begin
      entry[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + Q_PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + Q_PTR_W'(1);
      end
      case ({push, pop})
        2'b10:   count <= count + Q_CNT_W'(1);
        2'b01:   count <= count - Q_CNT_W'(1);
        default: count <= count;
      endcase
    end
  end

endmodule

// ===== rtl/core/pwe_back.sv =====
// Back end: weight, value and tangent term through one shared 32x32 multiplier, the
// residual, then the saturating totals and the output register. Depends on pwe_pkg.
module pwe_back (
  input  logic            clk,
  input  logic            rst,
  input  pwe_pkg::cfg_t   cfg,
  input  logic            pop_valid,
  output logic            pop_ready,
  input  pwe_pkg::item_t  pop_data,
  pwe_out_if.source       result
);
  import pwe_pkg::*;

  typedef enum logic [2:0] {
    B_IDLE, B_M1, B_WGT, B_M2, B_VAL, B_M3, B_TERM, B_ACC
  } bstate_t;

  bstate_t             state;
  item_t               it;
  logic [PROD_W-1:0]   prod;
  logic [SQ_W-1:0]     sq;
  logic                sq_lt_lam;
  logic [VAL_W-1:0]    w;
  logic [VAL_W-1:0]    v;
  logic                v_ovf;
  logic [STAT_W-1:0]   res;
  logic [WA_W-1:0]     wa;
  logic [VAL_W-1:0]    tg;
  logic [SUM_W-1:0]    acc_p;
  logic [SUM_W-1:0]    acc_w;
  logic [SUM_W-1:0]    acc_t;
  logic [STAT_W-1:0]   acc_s;
  logic                ovf_seen;
  logic                out_valid;
  logic [VAL_W-1:0]    o_weight;
  logic [VAL_W-1:0]    o_value;
  logic [TOTAL_W-1:0]  o_ptot;
  logic [TOTAL_W-1:0]  o_wtot;
  logic [TOTAL_W-1:0]  o_ttot;
  logic [STAT_W-1:0]   o_stat;
  logic                o_ovf;
  logic                o_last;

  logic                    scad;
  logic                    lam_zero;
  logic [HI_W-1:0]         lam_t;
  logic [DATA_W-1:0]       mul_a;
  logic [DATA_W-1:0]       mul_b;
  logic [PROD_W-1:0]       mul_p;
  logic [SQ_W:0]           span_x;
  logic [HI_W-1:0]         prod_hi;
  logic [H25_W-1:0]        prod_h25;
  logic [VAL_W-1:0]        w_next;
  logic [HI_W-1:0]         x;
  logic                    x_sat;
  logic [VAL_W-1:0]        v_next;
  logic                    v_ovf_next;
  logic signed [DATA_W+1:0] g_x;
  logic signed [DATA_W+1:0] w_x;
  logic signed [DATA_W+1:0] ag_x;
  logic signed [DATA_W+1:0] r_x;
  logic [STAT_W-1:0]       res_next;
  logic [HI_W-1:0]         v_x;
  logic [VAL_W-1:0]        tg_next;
  logic [SUM_W:0]          p_sum;
  logic [SUM_W:0]          w_sum;
  logic [SUM_W:0]          t_sum;
  logic                    sat_p;
  logic                    sat_w;
  logic                    sat_t;
  logic [SUM_W-1:0]        p_new;
  logic [SUM_W-1:0]        w_new;
  logic [SUM_W-1:0]        t_new;
  logic [STAT_W-1:0]       s_new;
  logic                    ovf_new;
  logic                    take;

  assign scad      = (cfg.mode == MODE_SCAD);
  assign lam_zero  = (cfg.lambda == '0);
  assign lam_t     = HI_W'(cfg.lambda);
  assign pop_ready = (state == B_IDLE);
  assign prod_hi   = prod[PROD_W-1:FRAC_W];
  assign prod_h25  = prod[PROD_W-1:FRAC_W+1];

  // 2*lambda - drop; only used where the drop is below lambda, so it fits 32 bits
  assign span_x = (SQ_W+1)'({cfg.lambda, 1'b0}) - (SQ_W+1)'(sq);

  always_comb begin
    case (state)
      B_M1: begin
        if (!scad) begin
          mul_a = it.mag;
          mul_b = DATA_W'(cfg.rg);
        end else if (it.a_le_lam) begin
          mul_a = it.mag;
          mul_b = DATA_W'(cfg.lambda);
        end else begin
          mul_a = it.excess;
          mul_b = DATA_W'(cfg.rgl);
        end
      end
      B_M2: begin
        mul_a = scad ? it.excess : it.mag;
        mul_b = span_x[DATA_W-1:0];
      end
      B_M3: begin
        mul_a = it.mag;
        mul_b = DATA_W'(w);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign mul_p = mul_a * mul_b;

  // weight from the first product: lambda less the slope drop, floored at zero; lambda for SCAD with |beta| <= lambda
  always_comb begin
    if (lam_zero) begin
      w_next = '0;
    end else if (scad && it.a_le_lam) begin
      w_next = cfg.lambda;
    end else if (lam_t > prod_hi) begin
      w_next = VAL_W'(lam_t - prod_hi);
    end else begin
      w_next = '0;
    end
  end

  // penalty value from the second product (the first for SCAD with |beta| <= lambda), or the flat level past the knee
  always_comb begin
    if (scad && it.a_le_lam) begin
      x = HI_W'(sq);
    end else if (scad) begin
      x = HI_W'(cfg.l2) + HI_W'(prod_h25);
    end else begin
      x = HI_W'(prod_h25);
    end
    x_sat = x > HI_W'(VAL_MAX);
    if (lam_zero || it.a_zero) begin
      v_next     = '0;
      v_ovf_next = 1'b0;
    end else if (!(scad && it.a_le_lam) && !sq_lt_lam) begin
      v_next     = scad ? cfg.flat_scad : cfg.flat_mcp;
      v_ovf_next = scad ? cfg.flat_scad_sat : cfg.flat_mcp_sat;
    end else if (x_sat) begin
      v_next     = VAL_MAX;
      v_ovf_next = 1'b1;
    end else begin
      v_next     = x[VAL_W-1:0];
      v_ovf_next = 1'b0;
    end
  end

  assign g_x  = (DATA_W+2)'(it.gradient);
  assign w_x  = $signed((DATA_W+2)'(w));
  assign ag_x = (g_x < 0) ? -g_x : g_x;

  always_comb begin
    case (it.zone)
      ZONE_POS: r_x = g_x + w_x;
      ZONE_NEG: r_x = g_x - w_x;
      ZONE_ZERO: begin
        r_x = ag_x - w_x;
        if (r_x < 0) begin
          r_x = '0;
        end
      end
      default: r_x = '0;
    endcase
    res_next = (r_x < 0) ? STAT_W'(-r_x) : STAT_W'(r_x);
  end

  // tangent term: value less weight*|beta|, clamped at zero
  assign v_x     = HI_W'(v);
  assign tg_next = (v_x > prod_hi) ? VAL_W'(v_x - prod_hi) : '0;

  assign p_sum   = (SUM_W+1)'(acc_p) + (SUM_W+1)'(v);
  assign w_sum   = (SUM_W+1)'(acc_w) + (SUM_W+1)'(wa);
  assign t_sum   = (SUM_W+1)'(acc_t) + (SUM_W+1)'(tg);
  assign sat_p   = p_sum > (SUM_W+1)'(SUM_MAX);
  assign sat_w   = w_sum > (SUM_W+1)'(SUM_MAX);
  assign sat_t   = t_sum > (SUM_W+1)'(SUM_MAX);
  assign p_new   = sat_p ? SUM_MAX : p_sum[SUM_W-1:0];
  assign w_new   = sat_w ? SUM_MAX : w_sum[SUM_W-1:0];
  assign t_new   = sat_t ? SUM_MAX : t_sum[SUM_W-1:0];
  assign s_new   = (res > acc_s) ? res : acc_s;
  assign ovf_new = ovf_seen || v_ovf || sat_p || sat_w || sat_t;
  assign take    = !out_valid || result.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= B_IDLE;
      out_valid <= 1'b0;
      acc_p     <= '0;
      acc_w     <= '0;
      acc_t     <= '0;
      acc_s     <= '0;
      ovf_seen  <= 1'b0;
    end else begin
      // the last step owns the output register while it is active
      if (out_valid && result.ready && state != B_ACC) begin
        out_valid <= 1'b0;
      end
      case (state)
        B_IDLE: begin
          if (pop_valid) begin
            it    <= pop_data;
            state <= B_M1;
          end
        end
        B_M1: begin
          prod  <= mul_p;
          state <= B_WGT;
        end
        B_WGT: begin
          w         <= w_next;
          sq        <= prod_hi[SQ_W-1:0];
          sq_lt_lam <= prod_hi < lam_t;
          state     <= B_M2;
        end
        B_M2: begin
          prod  <= mul_p;
          state <= B_VAL;
        end
        B_VAL: begin
          v     <= v_next;
          v_ovf <= v_ovf_next;
          res   <= res_next;
          state <= B_M3;
        end
        B_M3: begin
          prod  <= mul_p;
          state <= B_TERM;
        end
        B_TERM: begin
          wa    <= prod_hi[WA_W-1:0];
          tg    <= tg_next;
          state <= B_ACC;
        end
        B_ACC: begin
          // wait here until the output register is free
          if (take) begin
            out_valid <= 1'b1;
            o_weight  <= w;
            o_value   <= v;
            o_ptot    <= p_new[TOTAL_W-1:0];
            o_wtot    <= w_new[TOTAL_W-1:0];
            o_ttot    <= t_new[TOTAL_W-1:0];
            o_stat    <= s_new;
            o_ovf     <= ovf_new;
            o_last    <= it.last;
            if (it.last) begin
              acc_p    <= '0;
              acc_w    <= '0;
              acc_t    <= '0;
              acc_s    <= '0;
              ovf_seen <= 1'b0;
            end else begin
              acc_p    <= p_new;
              acc_w    <= w_new;
              acc_t    <= t_new;
              acc_s    <= s_new;
              ovf_seen <= ovf_new;
            end
            state <= B_IDLE;
          end
        end
        default: state <= B_IDLE;
      endcase
    end
  end

  assign result.valid             = out_valid;
  assign result.weight            = o_weight;
  assign result.penalty_value     = o_value;
  assign result.penalty_total     = o_ptot;
  assign result.weighted_l1_total = o_wtot;
  assign result.tangent_total     = o_ttot;
  assign result.stationarity_max  = o_stat;
  assign result.overflow          = o_ovf;
  assign result.last_result       = o_last;

endmodule

// ===== rtl/core/mcp_scad_penalty_weight_engine.sv =====
// Top level of the MCP/SCAD penalty weight engine: register file, front end,
// queue and back end. Depends on pwe_pkg, pwe_in_if, pwe_out_if and the pwe_* modules.
//
//   channel   dir  handshake          word
//   item      in   valid/ready        coefficient, gradient, last_item
//   result    out  valid/ready        weight, value, three totals, max residual, flags
//   apb       in   psel/penable       six registers at byte address 4*index
//
// For each word the back end pops the queue, makes three passes through the shared
// 32x32 multiplier each followed by a step that consumes the product, and then
// updates the totals and loads the output register before it pops the next word.
// The front end accepts a word whenever the two-entry queue has room and no rebuild
// runs, so input is taken while a result waits; a stalled result holds the back end in
// its last step. Any register write rebuilds lambda^2 and flat levels, input held off.
// Reset loads the register defaults and clears the totals; there is no clearing pass.
module mcp_scad_penalty_weight_engine (
  input  logic                             clk,
  input  logic                             rst,
  pwe_in_if.sink                           item,
  pwe_out_if.source                        result,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [pwe_pkg::PADDR_W-1:0]      paddr,
  input  logic [pwe_pkg::APB_DATA_W-1:0]   pwdata,
  output logic [pwe_pkg::APB_DATA_W-1:0]   prdata,
  output logic                             pready
);
  import pwe_pkg::*;

  cfg_t   cfg;
  logic   cfg_busy;
  logic   push_valid;
  logic   push_ready;
  item_t  push_data;
  logic   pop_valid;
  logic   pop_ready;
  item_t  pop_data;

  pwe_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg),
    .busy    (cfg_busy)
  );

  pwe_front u_front (
    .item       (item),
    .cfg        (cfg),
    .cfg_busy   (cfg_busy),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data)
  );

  pwe_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_data   (pop_data)
  );

  pwe_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .pop_valid (pop_valid),
    .pop_ready (pop_ready),
    .pop_data  (pop_data),
    .result    (result)
  );

endmodule
